/* design/mlsc_pkg.sv */
// shared types, constants and grammar tables for the manifest line and stream checker
package mlsc_pkg;

   typedef enum logic [1:0] {
      MODE_MANIFEST = 2'd0,
      MODE_SPEECH   = 2'd1,
      MODE_FINISH   = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REC_OPEN    = 2'd0,
      REC_SEALED  = 2'd1,
      REC_REFUSED = 2'd2
   } rec_status_type;

   typedef struct packed {
      rec_status_type status;
      logic [63:0]    digest;
      logic [63:0]    count;
   } claim_type;

   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;

   localparam logic [3:0] POS_DIGEST  = 4'd1;
   localparam logic [3:0] POS_BYTES   = 4'd3;
   localparam logic [3:0] POS_HAND    = 4'd7;
   localparam logic [3:0] POS_LAW     = 4'd9;
   localparam logic [3:0] POS_OPENING = 4'd11;
   localparam logic [3:0] POS_LAST    = 4'd15;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;

   localparam logic [24*8-1:0] LIT0 = "spoke: candidate-digest=";
   localparam logic [7*8-1:0]  LIT1 = " bytes=";
   localparam logic [6*8-1:0]  LIT2 = " seed=";
   localparam logic [6*8-1:0]  LIT3 = " hand=";
   localparam logic [5*8-1:0]  LIT4 = " law=";
   localparam logic [9*8-1:0]  LIT5 = " opening=";
   localparam logic [13*8-1:0] LIT6 = " lived-bytes=";
   localparam logic [9*8-1:0]  LIT7 = " episode=";

   localparam logic [3*8-1:0]  HAND0 = "uni";
   localparam logic [2*8-1:0]  HAND1 = "bi";
   localparam logic [3*8-1:0]  HAND2 = "tri";
   localparam logic [17*8-1:0] LAW0  = "supported-backoff";
   localparam logic [11*8-1:0] LAW1  = "laplace-red";

   function automatic logic [4:0] lit_len(input logic [2:0] k);
      logic [4:0] n;
      case (k)
         3'd0: n = 5'd24;
         3'd1: n = 5'd7;
         3'd2: n = 5'd6;
         3'd3: n = 5'd6;
         3'd4: n = 5'd5;
         3'd5: n = 5'd9;
         3'd6: n = 5'd13;
         default: n = 5'd9;
      endcase
      return n;
   endfunction

   // character c of literal k, zero past its end
   function automatic logic [7:0] lit_char(input logic [2:0] k, input logic [4:0] c);
      logic [7:0] ch;
      int         i;
      ch = 8'h00;
      i  = int'(c);
      case (k)
         3'd0: if (i < 24) ch = LIT0[8*(23 - i) +: 8];
         3'd1: if (i < 7)  ch = LIT1[8*(6 - i) +: 8];
         3'd2: if (i < 6)  ch = LIT2[8*(5 - i) +: 8];
         3'd3: if (i < 6)  ch = LIT3[8*(5 - i) +: 8];
         3'd4: if (i < 5)  ch = LIT4[8*(4 - i) +: 8];
         3'd5: if (i < 9)  ch = LIT5[8*(8 - i) +: 8];
         3'd6: if (i < 13) ch = LIT6[8*(12 - i) +: 8];
         default: if (i < 9) ch = LIT7[8*(8 - i) +: 8];
      endcase
      return ch;
   endfunction

   // length of the chosen word, zero for a choice that does not exist
   function automatic logic [4:0] word_len(input logic is_law, input logic [1:0] wc);
      logic [4:0] n;
      n = 5'd0;
      if (is_law) begin
         case (wc)
            2'd0: n = 5'd17;
            2'd1: n = 5'd11;
            default: n = 5'd0;
         endcase
      end else begin
         case (wc)
            2'd0: n = 5'd3;
            2'd1: n = 5'd2;
            2'd2: n = 5'd3;
            default: n = 5'd0;
         endcase
      end
      return n;
   endfunction

   function automatic logic [7:0] word_char(input logic is_law, input logic [1:0] wc,
                                            input logic [4:0] c);
      logic [7:0] ch;
      int         i;
      ch = 8'h00;
      i  = int'(c);
      if (is_law) begin
         case (wc)
            2'd0: if (i < 17) ch = LAW0[8*(16 - i) +: 8];
            2'd1: if (i < 11) ch = LAW1[8*(10 - i) +: 8];
            default: ch = 8'h00;
         endcase
      end else begin
         case (wc)
            2'd0: if (i < 3) ch = HAND0[8*(2 - i) +: 8];
            2'd1: if (i < 2) ch = HAND1[8*(1 - i) +: 8];
            2'd2: if (i < 3) ch = HAND2[8*(2 - i) +: 8];
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

endpackage

/* design/mlsc_req_if.sv */
// request channel: mode and data byte with valid/ready
interface mlsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;
   modport source(output valid, output mode, output data_byte, input ready);
   modport sink(input valid, input mode, input data_byte, output ready);
endinterface

/* design/mlsc_rsp_if.sv */
// response channel: verdict, byte count and digest with valid/ready
interface mlsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        verdict;
   logic [63:0] byte_count;
   logic [63:0] stream_digest;
   modport source(output valid, output verdict, output byte_count, output stream_digest,
                  input ready);
   modport sink(input valid, input verdict, input byte_count, input stream_digest,
                output ready);
endinterface

/* design/manifest_line_and_stream_checker.sv */
// top level: manifest recognizer, fnv-1a stream hash and two-entry result queue
//
//  channel   port     dir   fields
//  request   req_ch   in    mode[1:0], data_byte[7:0]
//  response  rsp_ch   out   verdict, byte_count[63:0], stream_digest[63:0]
//
// one item per cycle while req_ch.ready is high: every item finishes in the cycle it is accepted
// a finish item's result is registered into the head slot, or into the spare slot when the head stays occupied
// two result slots: req_ch.ready drops only when both hold unread results
// synchronous active-high reset returns the recognizer to the line start,
// the hash to the fnv offset basis and empties the result queue
// a finish item also returns all checking state to its reset values
module manifest_line_and_stream_checker
   import mlsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mlsc_req_if.sink   req_ch,
   mlsc_rsp_if.source rsp_ch
);

   typedef struct packed {
      logic        verdict;
      logic [63:0] byte_count;
      logic [63:0] stream_digest;
   } result_type;

   // handshake and item decode
   logic        req_fire;
   logic        manifest_en;
   logic        speech_en;
   logic        finish_en;

   // stream hash and count
   logic [63:0] hash_ff, hash_in;
   logic [63:0] count_ff, count_in;
   logic [63:0] hash_x;

   claim_type   claim;
   result_type  result;

   // result queue: head slot drives the port, spare slot takes a result while head stalls
   logic        head_valid_ff, head_valid_in;
   logic        spare_valid_ff, spare_valid_in;
   result_type  head_ff, head_in;
   result_type  spare_ff, spare_in;
   logic        pop;

   assign req_ch.ready = !spare_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign manifest_en  = req_fire && (req_ch.mode == MODE_MANIFEST);
   assign speech_en    = req_fire && (req_ch.mode == MODE_SPEECH);
   assign finish_en    = req_fire && (req_ch.mode == MODE_FINISH);

   mlsc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (manifest_en),
      .clear     (finish_en),
      .data_byte (req_ch.data_byte),
      .claim     (claim)
   );

   // fnv-1a step: multiply by 2^40 + 0x1b3 as a sum of shifts
   always_comb begin
      hash_x = hash_ff ^ {56'd0, req_ch.data_byte};
      hash_in  = hash_ff;
      count_in = count_ff;
      if (finish_en) begin
         hash_in  = FNV_BASIS;
         count_in = 64'd0;
      end else if (speech_en) begin
         hash_in  = hash_x + (hash_x << 40) + (hash_x << 8) + (hash_x << 7)
                  + (hash_x << 5) + (hash_x << 4) + (hash_x << 1);
         count_in = count_ff + 64'd1;
      end
   end

   // verdict from the state before this finish item
   always_comb begin
      result.verdict       = !(claim.status == REC_SEALED && hash_ff == claim.digest
                               && count_ff == claim.count);
      result.byte_count    = count_ff;
      result.stream_digest = hash_ff;
   end

   assign pop = head_valid_ff && rsp_ch.ready;

   always_comb begin
      head_valid_in  = head_valid_ff;
      spare_valid_in = spare_valid_ff;
      head_in        = head_ff;
      spare_in       = spare_ff;
      if (pop) begin
         head_in        = spare_ff;
         head_valid_in  = spare_valid_ff;
         spare_valid_in = 1'b0;
      end
      if (finish_en) begin
         if (!head_valid_in) begin
            head_valid_in = 1'b1;
            head_in       = result;
         end else begin
            spare_valid_in = 1'b1;
            spare_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff        <= FNV_BASIS;
         count_ff       <= 64'd0;
         head_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         hash_ff        <= hash_in;
         count_ff       <= count_in;
         head_valid_ff  <= head_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

   assign rsp_ch.valid         = head_valid_ff;
   assign rsp_ch.verdict       = head_ff.verdict;
   assign rsp_ch.byte_count    = head_ff.byte_count;
   assign rsp_ch.stream_digest = head_ff.stream_digest;

`ifndef SYNTH
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> head_valid_ff)
      else $error("spare slot holds a result while the head is empty");
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      finish_en |=> hash_ff == FNV_BASIS && count_ff == 64'd0)
      else $error("stream state not cleared after finish");
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      finish_en && !head_valid_ff |=> rsp_ch.valid && rsp_ch.byte_count == $past(count_ff))
      else $error("finish result missing from the head slot");
   a_no_result_without_finish: assert property (@(posedge clock) disable iff (reset)
      !finish_en && !head_valid_ff |=> !head_valid_ff)
      else $error("result appeared without a finish item");
`endif

endmodule

/* design/mlsc_parser.sv */
// manifest line recognizer: one byte per cycle, holds the claimed digest and count
module mlsc_parser
   import mlsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_en,
   input  logic        clear,
   input  logic [7:0]  data_byte,
   output claim_type   claim
);

   logic [3:0]     pos_ff, pos_in;
   logic [1:0]     wc_ff, wc_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [63:0]    acc_ff, acc_in;
   logic [63:0]    digest_ff, digest_in;
   logic [63:0]    count_ff, count_in;
   rec_status_type status_ff, status_in;
   logic           cr_ff, cr_in;

   logic           refuse;
   logic [4:0]     lit_n;
   logic [4:0]     cnt_inc;
   logic           is_law;
   logic [4:0]     wlen;
   logic           complete;
   logic           hex_ok;
   logic [3:0]     hex_val;
   logic           is_digit;
   logic [3:0]     digit;
   logic [63:0]    acc_x10;
   logic           overflow;

   always_comb begin
      lit_n    = lit_len(pos_ff[3:1]);
      cnt_inc  = 5'(cnt_ff + 5'd1);
      is_law   = (pos_ff == POS_LAW);
      wlen     = word_len(is_law, wc_ff);
      is_digit = (data_byte >= "0") && (data_byte <= "9");
      digit    = 4'(data_byte - 8'h30);
      hex_ok   = 1'b1;
      hex_val  = digit;
      if (is_digit) begin
         hex_val = digit;
      end else if (data_byte >= "a" && data_byte <= "f") begin
         hex_val = 4'(data_byte - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
      acc_x10  = (acc_ff << 3) + (acc_ff << 1);
      overflow = (acc_ff > DEC_LIMIT) || (acc_ff == DEC_LIMIT && digit > 4'd5);
      case (pos_ff) inside
         POS_DIGEST:        complete = (cnt_ff == 5'd16);
         POS_HAND, POS_LAW: complete = (wlen != 5'd0) && (cnt_ff == wlen);
         POS_OPENING:       complete = (cnt_ff == 5'd4);
         default:           complete = (cnt_ff != 5'd0);
      endcase
   end

   always_comb begin
      pos_in    = pos_ff;
      wc_in     = wc_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      digest_in = digest_ff;
      count_in  = count_ff;
      status_in = status_ff;
      cr_in     = cr_ff;
      refuse    = 1'b0;
      if (clear) begin
         pos_in    = 4'd0;
         wc_in     = 2'd0;
         cnt_in    = 5'd0;
         acc_in    = 64'd0;
         digest_in = 64'd0;
         count_in  = 64'd0;
         status_in = REC_OPEN;
         cr_in     = 1'b0;
      end else if (byte_en) begin
         if (status_ff != REC_OPEN) begin
            refuse = 1'b1;
         end else if (!pos_ff[0]) begin
            if (cnt_ff >= lit_n || lit_char(pos_ff[3:1], cnt_ff) != data_byte) begin
               refuse = 1'b1;
            end else if (cnt_inc == lit_n) begin
               pos_in = 4'(pos_ff + 4'd1);
               cnt_in = 5'd0;
               acc_in = 64'd0;
               wc_in  = 2'd0;
            end else begin
               cnt_in = cnt_inc;
            end
         end else if (pos_ff == POS_LAST && cr_ff) begin
            if (data_byte == CHAR_LF) status_in = REC_SEALED;
            else refuse = 1'b1;
         end else if (pos_ff == POS_LAST && (data_byte == CHAR_CR || data_byte == CHAR_LF)) begin
            if (!complete) refuse = 1'b1;
            else if (data_byte == CHAR_CR) cr_in = 1'b1;
            else status_in = REC_SEALED;
         end else if (pos_ff != POS_LAST && data_byte == CHAR_SPACE) begin
            if (!complete) begin
               refuse = 1'b1;
            end else begin
               if (pos_ff == POS_BYTES) count_in = acc_ff;
               pos_in = 4'(pos_ff + 4'd1);
               // the leading space of the next literal is already taken
               cnt_in = 5'd1;
            end
         end else if (pos_ff == POS_DIGEST || pos_ff == POS_OPENING) begin
            if (!hex_ok || cnt_ff >= ((pos_ff == POS_DIGEST) ? 5'd16 : 5'd4)) begin
               refuse = 1'b1;
            end else begin
               if (pos_ff == POS_DIGEST) digest_in = {digest_ff[59:0], hex_val};
               cnt_in = cnt_inc;
            end
         end else if (pos_ff == POS_HAND || pos_ff == POS_LAW) begin
            if (cnt_ff == 5'd0) begin
               cnt_in = 5'd1;
               if (is_law) begin
                  if (data_byte == "s") wc_in = 2'd0;
                  else if (data_byte == "l") wc_in = 2'd1;
                  else refuse = 1'b1;
               end else begin
                  if (data_byte == "u") wc_in = 2'd0;
                  else if (data_byte == "b") wc_in = 2'd1;
                  else if (data_byte == "t") wc_in = 2'd2;
                  else refuse = 1'b1;
               end
            end else if (cnt_ff >= wlen || word_char(is_law, wc_ff, cnt_ff) != data_byte) begin
               refuse = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end else begin
            // canonical decimal that fits in 64 bits
            if (!is_digit || (cnt_ff != 5'd0 && acc_ff == 64'd0) || overflow) begin
               refuse = 1'b1;
            end else begin
               acc_in = acc_x10 + {60'd0, digit};
               if (cnt_ff < 5'd31) cnt_in = cnt_inc;
            end
         end
         if (refuse) status_in = REC_REFUSED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 4'd0;
         wc_ff     <= 2'd0;
         cnt_ff    <= 5'd0;
         acc_ff    <= 64'd0;
         digest_ff <= 64'd0;
         count_ff  <= 64'd0;
         status_ff <= REC_OPEN;
         cr_ff     <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         wc_ff     <= wc_in;
         cnt_ff    <= cnt_in;
         acc_ff    <= acc_in;
         digest_ff <= digest_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         cr_ff     <= cr_in;
      end
   end

   assign claim.status = status_ff;
   assign claim.digest = digest_ff;
   assign claim.count  = count_ff;

`ifndef SYNTH
   a_sealed_at_end: assert property (@(posedge clock) disable iff (reset)
      status_ff == REC_SEALED |-> pos_ff == POS_LAST)
      else $error("record sealed before the last field");
   a_cr_at_end: assert property (@(posedge clock) disable iff (reset)
      cr_ff |-> pos_ff == POS_LAST)
      else $error("carriage return seen outside the last field");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      clear |=> pos_ff == 4'd0 && status_ff == REC_OPEN && !cr_ff && cnt_ff == 5'd0)
      else $error("recognizer not back at the start after finish");
   a_refused_sticks: assert property (@(posedge clock) disable iff (reset)
      status_ff == REC_REFUSED && !clear |=> status_ff == REC_REFUSED)
      else $error("refused record reopened");
`endif

endmodule

/* tb/manifest_line_and_stream_checker_tb.sv */
// testbench for the manifest line and stream checker: directed and random byte streams
module manifest_line_and_stream_checker_tb
   import mlsc_pkg::*;
();

   typedef struct packed {
      logic        verdict;
      logic [63:0] count;
      logic [63:0] digest;
   } verdict_type;

   logic clock;
   logic reset;

   mlsc_req_if req_ch();
   mlsc_rsp_if rsp_ch();

   manifest_line_and_stream_checker dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // ---------------------------------------------------------------
   // predictor state, a copy of the block's checking state
   // ---------------------------------------------------------------
   logic [7:0]     pos;
   logic [1:0]     word;
   logic [4:0]     nchar;
   logic [63:0]    acc;
   logic [63:0]    claim_digest;
   logic [63:0]    claim_count;
   rec_status_type rec;
   logic           got_cr;
   logic [63:0]    hash;
   logic [63:0]    nspeech;

   verdict_type verdicts_due[$];
   int          errors;

   // idle percentages for sender and receiver
   int send_idle;
   int recv_stall;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400000000;
      $display("simulation failed");
      $finish;
   end

   function automatic void clear_model();
      pos = 8'd0;
      word = 2'd0;
      nchar = 5'd0;
      acc = 64'd0;
      claim_digest = 64'd0;
      claim_count = 64'd0;
      rec = REC_OPEN;
      got_cr = 1'b0;
      hash = FNV_BASIS;
      nspeech = 64'd0;
   endfunction

   function automatic logic [7:0] literal_byte(int k, int c);
      string s;
      case (k)
         0: s = "spoke: candidate-digest=";
         1: s = " bytes=";
         2: s = " seed=";
         3: s = " hand=";
         4: s = " law=";
         5: s = " opening=";
         6: s = " lived-bytes=";
         default: s = " episode=";
      endcase
      return (c < s.len()) ? s[c] : 8'h00;
   endfunction

   function automatic int literal_len(int k);
      int lens[8] = '{24, 7, 6, 6, 5, 9, 13, 9};
      return lens[k];
   endfunction

   function automatic string choice_word(logic is_law, int wc);
      if (is_law) return (wc == 0) ? "supported-backoff" : "laplace-red";
      case (wc)
         0: return "uni";
         1: return "bi";
         default: return "tri";
      endcase
   endfunction

   function automatic int hex_digit(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      return -1;
   endfunction

   function automatic logic field_done(int p);
      int    c;
      string hw;
      string lw;
      c  = nchar;
      hw = choice_word(1'b0, int'(word));
      lw = choice_word(1'b1, int'(word));
      case (p)
         1: return c == 16;
         7: return word < 3 && c == hw.len();
         9: return word < 2 && c == lw.len();
         11: return c == 4;
         default: return c >= 1;
      endcase
   endfunction

   // one character of field p; returns 0 when the line must be refused
   function automatic logic field_take(int p, logic [7:0] b);
      int    c;
      int    v;
      string w;
      logic [63:0] d;
      c = nchar;
      if (p == 1 || p == 11) begin
         v = hex_digit(b);
         if (v < 0 || c >= ((p == 1) ? 16 : 4)) return 1'b0;
         if (p == 1) claim_digest = {claim_digest[59:0], 4'(v)};
         nchar = 5'(c + 1);
         return 1'b1;
      end
      if (p == 7 || p == 9) begin
         if (c == 0) begin
            if (p == 7) begin
               if (b == "u") word = 2'd0;
               else if (b == "b") word = 2'd1;
               else if (b == "t") word = 2'd2;
               else return 1'b0;
            end else begin
               if (b == "s") word = 2'd0;
               else if (b == "l") word = 2'd1;
               else return 1'b0;
            end
            nchar = 5'd1;
            return 1'b1;
         end
         if (p == 7 && word > 2) return 1'b0;
         if (p == 9 && word > 1) return 1'b0;
         w = choice_word(p == 9, word);
         if (c >= w.len() || w[c] != b) return 1'b0;
         nchar = 5'(c + 1);
         return 1'b1;
      end
      // decimal field
      if (b < "0" || b > "9") return 1'b0;
      d = 64'(b - "0");
      if (c >= 1 && acc == 64'd0) return 1'b0;
      if (acc > DEC_LIMIT || (acc == DEC_LIMIT && d > 5)) return 1'b0;
      acc = acc * 10 + d;
      if (c < 31) nchar = 5'(c + 1);
      return 1'b1;
   endfunction

   function automatic void line_byte(logic [7:0] b);
      int p;
      int k;
      int c;
      p = pos;
      if (rec != REC_OPEN || p > 15) begin
         rec = REC_REFUSED;
         return;
      end
      if (p % 2 == 0) begin
         k = p / 2;
         c = nchar;
         if (c >= literal_len(k) || literal_byte(k, c) != b) begin
            rec = REC_REFUSED;
            return;
         end
         c++;
         if (c == literal_len(k)) begin
            pos = 8'(p + 1);
            nchar = 5'd0;
            acc = 64'd0;
            word = 2'd0;
         end else begin
            nchar = 5'(c);
         end
         return;
      end
      if (p == 15) begin
         if (got_cr) begin
            rec = (b == CHAR_LF) ? REC_SEALED : REC_REFUSED;
            return;
         end
         if (b == CHAR_CR || b == CHAR_LF) begin
            if (!field_done(p)) rec = REC_REFUSED;
            else if (b == CHAR_CR) got_cr = 1'b1;
            else rec = REC_SEALED;
            return;
         end
         if (!field_take(p, b)) rec = REC_REFUSED;
         return;
      end
      if (b == CHAR_SPACE) begin
         if (!field_done(p)) begin
            rec = REC_REFUSED;
            return;
         end
         if (p == 3) claim_count = acc;
         pos = 8'(p + 1);
         // the space counts as the first character of the next literal
         nchar = 5'd1;
         return;
      end
      if (!field_take(p, b)) rec = REC_REFUSED;
   endfunction

   function automatic void predict_item(logic [1:0] m, logic [7:0] b);
      verdict_type v;
      case (mode_type'(m))
         MODE_MANIFEST: line_byte(b);
         MODE_SPEECH: begin
            hash = (hash ^ 64'(b)) * 64'h100000001b3;
            nspeech = nspeech + 64'd1;
         end
         MODE_FINISH: begin
            v.verdict = !(rec == REC_SEALED && hash == claim_digest &&
                          nspeech == claim_count);
            v.count = nspeech;
            v.digest = hash;
            verdicts_due.push_back(v);
            clear_model();
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // sender: one item, with random idle cycles before it
   // ---------------------------------------------------------------
   task automatic send_item(logic [1:0] m, logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= m;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_item(m, b);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(MODE_MANIFEST, s[i]);
   endtask

   task automatic send_speech(int n);
      repeat (n) send_item(MODE_SPEECH, 8'($urandom_range(255)));
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (verdicts_due.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   // hex text of a digest; the predictor hash of the speech already sent is used directly
   function automatic string hex16(logic [63:0] v);
      return $sformatf("%016h", v);
   endfunction

   function automatic string dec_text(logic [63:0] v);
      return $sformatf("%0d", v);
   endfunction

   // builds a full line without its line end; flavor picks the words, flavor zero puts the largest episode
   function automatic string make_line(logic [63:0] dig, logic [63:0] cnt, int flavor);
      string s;
      logic [63:0] ep;
      ep = (flavor == 0) ? 64'hffffffffffffffff : 64'($urandom_range(99));
      s = {"spoke: candidate-digest=", hex16(dig), " bytes=", dec_text(cnt),
           " seed=", dec_text(64'($urandom_range(99))),
           " hand=", choice_word(1'b0, flavor % 3),
           " law=", choice_word(1'b1, flavor % 2),
           " opening=", $sformatf("%04h", 16'($urandom)),
           " lived-bytes=", dec_text(64'($urandom_range(999))),
           " episode=", dec_text(ep)};
      return s;
   endfunction

   // speech is sent first, so the line can claim the true digest and count
   task automatic good_record(int nbytes, int flavor, logic use_cr);
      string s;
      send_speech(nbytes);
      s = make_line(hash, nspeech, flavor);
      send_text(s);
      if (use_cr) send_item(MODE_MANIFEST, CHAR_CR);
      send_item(MODE_MANIFEST, CHAR_LF);
      send_item(MODE_FINISH, 8'($urandom));
   endtask

   // ---------------------------------------------------------------
   // checker: every accepted result against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type v;
      if (!reset) rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdicts_due.size() == 0) begin
            $error("result with no expectation waiting");
            errors++;
         end else begin
            v = verdicts_due.pop_front();
            if (rsp_ch.verdict !== v.verdict) begin
               $error("verdict expected %0d actual %0d", v.verdict, rsp_ch.verdict);
               errors++;
            end
            if (rsp_ch.byte_count !== v.count) begin
               $error("byte_count expected %0d actual %0d", v.count, rsp_ch.byte_count);
               errors++;
            end
            if (rsp_ch.stream_digest !== v.digest) begin
               $error("stream_digest expected %h actual %h", v.digest,
                      rsp_ch.stream_digest);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // test tasks
   // ---------------------------------------------------------------
   task automatic test_well_formed();
      good_record(2, 0, 1'b1);
   endtask

   task automatic test_special_cases();
      // missing lf, finish right after the previous record's finish
      send_item(MODE_FINISH, 8'hff);
      // nul in the prefix
      send_text("spo");
      send_item(MODE_MANIFEST, 8'h00);
      send_item(MODE_FINISH, 8'h00);
      // byte after lf, ignored mode three in between
      send_text(make_line(hash, nspeech, 1));
      send_item(MODE_MANIFEST, CHAR_LF);
      send_item(MODE_NONE, 8'h55);
      send_item(MODE_MANIFEST, 8'hff);
      send_item(MODE_FINISH, 8'h00);
      // upper-case hex, leading zero, overflow, second cr
      send_text("spoke: candidate-digest=A");
      send_item(MODE_FINISH, 8'h00);
      send_text("spoke: candidate-digest=0123456789abcdef bytes=01");
      send_item(MODE_FINISH, 8'h00);
      send_text("spoke: candidate-digest=0123456789abcdef bytes=18446744073709551616");
      send_item(MODE_FINISH, 8'h00);
      send_text({make_line(hash, nspeech, 2), "\r\r\n"});
      send_item(MODE_FINISH, 8'h00);
   endtask

   // random records: some well formed, some corrupted prefixes, mostly noise
   task automatic test_random(int nrec);
      string s;
      int    k;
      int    n;
      repeat (nrec) begin
         case ($urandom_range(9))
            0: good_record($urandom_range(3), $urandom_range(5), 1'($urandom));
            1, 2, 3: begin
               send_speech($urandom_range(2));
               s = make_line(hash, nspeech, $urandom_range(5));
               n = $urandom_range(40, 1);
               s = s.substr(0, n - 1);
               k = $urandom_range(n - 1);
               s[k] = ($urandom_range(1)) ? 8'($urandom) : s[k] ^ 8'h01;
               for (int i = 0; i < s.len(); i++) begin
                  if ($urandom_range(15) == 0) send_speech(1);
                  send_item(MODE_MANIFEST, s[i]);
               end
               send_item(MODE_FINISH, 8'($urandom));
            end
            default: begin
               repeat ($urandom_range(6)) send_item(2'($urandom), 8'($urandom));
               send_item(MODE_FINISH, 8'($urandom));
            end
         endcase
      end
   endtask

   task automatic test_paused_sender();
      send_item(MODE_FINISH, 8'($urandom));
      wait_drained();
      send_item(MODE_FINISH, 8'($urandom));
   endtask

   initial begin
      errors = 0;
      send_idle = 0;
      recv_stall = 0;
      clear_model();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_NONE;
      req_ch.data_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_well_formed();
      test_special_cases();
      test_random(2);
      send_idle = 75;
      test_random(2);
      send_idle = 0;
      recv_stall = 75;
      test_random(2);
      send_idle = 13;
      recv_stall = 13;
      test_paused_sender();
      test_random(2);
      send_idle = 0;
      recv_stall = 0;
      wait_drained();
      if (errors == 0 && verdicts_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (verdicts_due.size() != 0) $error("expected results left over");
         $display("simulation failed");
      end
      $finish;
   end

endmodule
